/* hw/rtl/erle_pkg.sv */
// package for the escape run-length byte decoder
// holds escape constants, queue sizing and the result record type
// no dependencies
`default_nettype none

package erle_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'h81;
   localparam logic [7:0] RUN_BYTE   = 8'h82;
   localparam logic [7:0] COUNT_BIAS = 8'd2;

   // output queue sizing, pointers wrap naturally
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] out_value;
      logic [7:0] run_count;
      logic       last_of_item;
   } rsp_type;

   // what one decoded byte produces
   typedef struct packed {
      logic [1:0] num_results;
      rsp_type    first;
      rsp_type    second;
   } decode_type;

endpackage

`default_nettype wire

/* hw/rtl/erle_core.sv */
// decode state and per-byte decode logic
// depends on erle_pkg
`default_nettype none

module erle_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic [7:0]          code_byte,
   output erle_pkg::decode_type     decode
);

   typedef enum logic [1:0] {
      PHASE_PLAIN = 2'd0,
      PHASE_ESC   = 2'd1,
      PHASE_COUNT = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] last_byte_ff, last_byte_in;

   always_comb begin
      phase_in     = phase_ff;
      last_byte_in = last_byte_ff;
      decode       = '0;
      case (phase_ff)
         PHASE_ESC: begin
            if (code_byte == erle_pkg::RUN_BYTE) begin
               phase_in = PHASE_COUNT;
            end else if (code_byte == erle_pkg::ESC_BYTE) begin
               // second escape stays pending
               decode.num_results = 2'd1;
               decode.first       = '{erle_pkg::ESC_BYTE, 8'd1, 1'b1};
               last_byte_in       = erle_pkg::ESC_BYTE;
            end else begin
               decode.num_results = 2'd2;
               decode.first       = '{erle_pkg::ESC_BYTE, 8'd1, 1'b0};
               decode.second      = '{code_byte, 8'd1, 1'b1};
               last_byte_in       = code_byte;
               phase_in           = PHASE_PLAIN;
            end
         end
         PHASE_COUNT: begin
            phase_in = PHASE_PLAIN;
            if (code_byte != 8'd0) begin
               decode.num_results = 2'd1;
               decode.first.out_value    = last_byte_ff;
               // count of one is clamped to a single copy
               decode.first.run_count    = (code_byte >= erle_pkg::COUNT_BIAS) ?
                                           code_byte - 8'd1 : 8'd1;
               decode.first.last_of_item = 1'b1;
            end else begin
               decode.num_results = 2'd2;
               decode.first       = '{erle_pkg::ESC_BYTE, 8'd1, 1'b0};
               decode.second      = '{erle_pkg::RUN_BYTE, 8'd1, 1'b1};
               last_byte_in       = erle_pkg::RUN_BYTE;
            end
         end
         default: begin
            // plain phase, also the unreachable code
            if (code_byte == erle_pkg::ESC_BYTE) begin
               phase_in = PHASE_ESC;
            end else begin
               phase_in           = PHASE_PLAIN;
               decode.num_results = 2'd1;
               decode.first       = '{code_byte, 8'd1, 1'b1};
               last_byte_in       = code_byte;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_PLAIN;
         last_byte_ff <= 8'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         last_byte_ff <= last_byte_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/erle_queue.sv */
// small result queue, up to two pushes and one pop per cycle
// depends on erle_pkg
`default_nettype none

module erle_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire erle_pkg::decode_type decode,
   output logic                     room,
   output logic                     head_valid,
   output erle_pkg::rsp_type        head,
   input  wire logic                pop
);

   erle_pkg::rsp_type                 mem_ff [erle_pkg::QUEUE_DEPTH];
   logic [erle_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [erle_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [erle_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [erle_pkg::CNT_W-1:0]        push_cnt;
   logic [erle_pkg::PTR_W-1:0]        wr_next;
   logic                              do_pop;

   // room for the largest burst, ignoring a same-cycle pop
   assign room       = count_ff <= erle_pkg::CNT_W'(erle_pkg::QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;
   assign wr_next    = wr_ptr_ff + erle_pkg::PTR_W'(1);
   assign push_cnt   = push ? erle_pkg::CNT_W'(decode.num_results) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + erle_pkg::PTR_W'(push_cnt);
      rd_ptr_in = do_pop ? rd_ptr_ff + erle_pkg::PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + push_cnt - erle_pkg::CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && decode.num_results != 2'd0) begin
         mem_ff[wr_ptr_ff] <= decode.first;
      end
      if (push && decode.num_results == 2'd2) begin
         mem_ff[wr_next] <= decode.second;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/escape_rle_byte_decoder_unit.sv */
// top level of the escape run-length byte decoder
// depends on erle_pkg, erle_core and erle_queue
//
// usage
//  - req channel: one compressed byte per request on req_code_byte
//  - rsp channel: decoded runs as value, repeat count and a last flag that
//    marks the final run produced by one compressed byte
//  - escape 0x81 0x82 n repeats the last output byte, 0x81 0x82 0 gives the
//    literal pair, 0x81 x gives 0x81 x; 0x81 0x81 gives 0x81 and stays escaped
//  - path: an accepted byte waits in the input register until the queue has
//    room, is decoded, and its runs enter the queue that drives rsp
//  - throughput: one byte per cycle while the queue has room; two runs of one
//    byte leave one at a time by the single read port of the four-entry queue
//  - bytes that yield no run (escape prefixes) leave rsp untouched
//  - reset: decode phase returns to plain literal, last byte to zero, the
//    input register and queue empty
//  - receiver stall: runs collect in the queue; once fewer than two slots
//    remain the decode stage holds and req_ready drops, nothing is lost
`default_nettype none

module escape_rle_byte_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_code_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_value,
   output logic [7:0]      rsp_run_count,
   output logic            rsp_last_of_item
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic                 room;
   logic                 decode_fire;
   logic                 head_valid;
   erle_pkg::rsp_type    head;
   erle_pkg::decode_type decode;

   // decode proceeds only when the queue can absorb a two-run burst
   assign decode_fire = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || decode_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (decode_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_code_byte;
      end
   end

   erle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (decode_fire),
      .code_byte (in_byte_ff),
      .decode    (decode)
   );

   erle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (decode_fire),
      .decode     (decode),
      .room       (room),
      .head_valid (head_valid),
      .head       (head),
      .pop        (rsp_ready)
   );

   assign rsp_valid        = head_valid;
   assign rsp_out_value    = head.out_value;
   assign rsp_run_count    = head.run_count;
   assign rsp_last_of_item = head.last_of_item;

endmodule

`default_nettype wire

/* hw/rtl/erle_checker.sv */
// port-level checks for the escape run-length byte decoder
// bound to escape_rle_byte_decoder_unit, depends on erle_pkg
`default_nettype none

module erle_port_checks (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_value,
   input wire logic [7:0] rsp_run_count,
   input wire logic       rsp_last_of_item
);

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled run holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_run_count) && $stable(rsp_last_of_item))
      else $error("stalled rsp payload changed");

   // a run always has at least one copy
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_count != 8'd0)
      else $error("zero run count");

   // the first of a pair is always the literal escape byte
   a_first_is_escape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_item |->
         rsp_out_value == erle_pkg::ESC_BYTE && rsp_run_count == 8'd1)
      else $error("first run of a pair is not a single escape byte");

   // a first-of-pair run is followed by the closing run of that byte
   a_pair_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=> rsp_valid && rsp_last_of_item)
      else $error("pair not completed by a last run");

endmodule

bind escape_rle_byte_decoder_unit erle_port_checks u_erle_port_checks (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_value    (rsp_out_value),
   .rsp_run_count    (rsp_run_count),
   .rsp_last_of_item (rsp_last_of_item)
);

`default_nettype wire

/* test/erle_checker.sv */
// checker for the escape run-length byte decoder: watches both channels,
// predicts the decoded runs and compares them in order
// depends on erle_pkg
`default_nettype none

module erle_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_code_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_value,
   input  wire logic [7:0] rsp_run_count,
   input  wire logic       rsp_last_of_item,
   output int unsigned     mismatches,
   output int unsigned     runs_outstanding
);

   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_ESC   = 2'd1,
      PH_COUNT = 2'd2
   } decode_phase_type;

   decode_phase_type  phase;
   logic [7:0]        prev_value;
   erle_pkg::rsp_type expected_runs[$];
   int unsigned       error_total;

   initial begin
      mismatches       = 0;
      runs_outstanding = 0;
      error_total      = 0;
      phase            = PH_PLAIN;
      prev_value       = 8'h00;
   end

   function automatic void queue_run(input logic [7:0] value, input logic [7:0] count,
                                     input logic last);
      erle_pkg::rsp_type r;
      r.out_value    = value;
      r.run_count    = count;
      r.last_of_item = last;
      expected_runs.push_back(r);
   endfunction

   task automatic decode_byte(input logic [7:0] b);
      logic [7:0] count;
      case (phase)
         PH_ESC: begin
            if (b == erle_pkg::RUN_BYTE) begin
               phase = PH_COUNT;
            end else if (b == erle_pkg::ESC_BYTE) begin
               // second escape stays pending
               prev_value = erle_pkg::ESC_BYTE;
               queue_run(erle_pkg::ESC_BYTE, 8'd1, 1'b1);
            end else begin
               queue_run(erle_pkg::ESC_BYTE, 8'd1, 1'b0);
               queue_run(b, 8'd1, 1'b1);
               prev_value = b;
               phase = PH_PLAIN;
            end
         end
         PH_COUNT: begin
            phase = PH_PLAIN;
            if (b != 8'h00) begin
               // count of one is clamped to a single copy
               count = (b >= erle_pkg::COUNT_BIAS) ? b - erle_pkg::COUNT_BIAS + 8'd1 : 8'd1;
               queue_run(prev_value, count, 1'b1);
            end else begin
               queue_run(erle_pkg::ESC_BYTE, 8'd1, 1'b0);
               queue_run(erle_pkg::RUN_BYTE, 8'd1, 1'b1);
               prev_value = erle_pkg::RUN_BYTE;
            end
         end
         default: begin
            if (b == erle_pkg::ESC_BYTE) begin
               phase = PH_ESC;
            end else begin
               prev_value = b;
               queue_run(b, 8'd1, 1'b1);
               phase = PH_PLAIN;
            end
         end
      endcase
   endtask

   task automatic check_run();
      erle_pkg::rsp_type want;
      if (expected_runs.size() == 0) begin
         $display("%0t: unexpected run value %02h count %0d last %0b", $time,
                  rsp_out_value, rsp_run_count, rsp_last_of_item);
         error_total++;
      end else begin
         want = expected_runs.pop_front();
         if (rsp_out_value !== want.out_value) begin
            $display("%0t: out_value expected %02h actual %02h", $time,
                     want.out_value, rsp_out_value);
            error_total++;
         end
         if (rsp_run_count !== want.run_count) begin
            $display("%0t: run_count expected %0d actual %0d", $time,
                     want.run_count, rsp_run_count);
            error_total++;
         end
         if (rsp_last_of_item !== want.last_of_item) begin
            $display("%0t: last_of_item expected %0b actual %0b", $time,
                     want.last_of_item, rsp_last_of_item);
            error_total++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_PLAIN;
         prev_value = 8'h00;
         expected_runs.delete();
      end else begin
         // a request cannot produce a run at its own edge, so order is free
         if (rsp_valid && rsp_ready) check_run();
         if (req_valid && req_ready) decode_byte(req_code_byte);
      end
      mismatches       <= error_total;
      runs_outstanding <= expected_runs.size();
   end

endmodule

`default_nettype wire

/* test/escape_rle_byte_decoder_unit_tb.sv */
// testbench top for the escape run-length byte decoder
// makes the request stream and random rsp stalls, gives the verdict
// depends on erle_pkg, erle_checker and the decoder rtl
`default_nettype none

module escape_rle_byte_decoder_unit_tb;

   // cycles with no request or result moving before giving up
   localparam int unsigned STALL_LIMIT = 2000;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_code_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_out_value;
   logic [7:0] rsp_run_count;
   logic       rsp_last_of_item;

   int unsigned mismatches;
   int unsigned runs_outstanding;
   int unsigned bytes_sent   = 0;
   int unsigned stall_cycles = 0;

   // idling switches for each side
   logic req_idle_en = 1'b1;
   logic rsp_idle_en = 1'b1;

   // opening stream: a repeat before any output (repeats the reset value 0),
   // extreme plain bytes, count of one clamp, count two, count 255, the
   // literal pair via count 0, a double escape left pending and then used as
   // a repeat prefix, a double escape followed by a literal, escape + other
   logic [7:0] opening_stream [0:28] = '{
      erle_pkg::ESC_BYTE, erle_pkg::RUN_BYTE, 8'h05,
      8'h00, 8'hFF,
      erle_pkg::ESC_BYTE, erle_pkg::RUN_BYTE, 8'h01,
      erle_pkg::ESC_BYTE, erle_pkg::RUN_BYTE, 8'h02,
      erle_pkg::ESC_BYTE, erle_pkg::RUN_BYTE, 8'hFF,
      erle_pkg::ESC_BYTE, erle_pkg::RUN_BYTE, 8'h00,
      erle_pkg::ESC_BYTE, erle_pkg::ESC_BYTE, erle_pkg::RUN_BYTE, 8'h03,
      erle_pkg::ESC_BYTE, erle_pkg::ESC_BYTE, 8'h41,
      erle_pkg::ESC_BYTE, 8'h7E,
      erle_pkg::ESC_BYTE, 8'hFF,
      8'h7F
   };

   // clock with period 4
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   escape_rle_byte_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_count    (rsp_run_count),
      .rsp_last_of_item (rsp_last_of_item)
   );

   erle_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_count    (rsp_run_count),
      .rsp_last_of_item (rsp_last_of_item),
      .mismatches       (mismatches),
      .runs_outstanding (runs_outstanding)
   );

   // receiver stalls about a third of the time while idling is on
   always @(posedge clock) begin
      rsp_ready <= !rsp_idle_en || ($urandom_range(99) >= 32);
   end

   // watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // one request: random idle cycles first, then hold valid until accepted;
   // valid is left high so a following request keeps it up without a dip
   task automatic send_byte(input logic [7:0] b);
      while (req_idle_en && $urandom_range(99) < 32) begin
         req_valid     <= 1'b0;
         req_code_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // sender holds off until every predicted run has been seen on rsp
   task automatic drain_runs();
      req_valid <= 1'b0;
      do @(posedge clock); while (runs_outstanding != 0);
   endtask

   // mostly well-formed escape sequences with random content, some noise
   task automatic random_burst(input int unsigned stop_at);
      int unsigned kind;
      logic [7:0]  b;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            // plain literal
            b = 8'($urandom_range(255));
            if (b == erle_pkg::ESC_BYTE) b = ~b;
            send_byte(b);
         end else if (kind < 65) begin
            // repeat sequence, with the count extremes weighted up
            case ($urandom_range(7))
               0:       b = 8'h00;
               1:       b = 8'h01;
               2:       b = 8'hFF;
               default: b = 8'($urandom_range(255));
            endcase
            send_byte(erle_pkg::ESC_BYTE);
            send_byte(erle_pkg::RUN_BYTE);
            send_byte(b);
         end else if (kind < 80) begin
            // escape followed by an arbitrary byte
            send_byte(erle_pkg::ESC_BYTE);
            send_byte(8'($urandom_range(255)));
         end else if (kind < 90) begin
            // double escape, leaves an escape pending
            send_byte(erle_pkg::ESC_BYTE);
            send_byte(erle_pkg::ESC_BYTE);
         end else begin
            // noise
            send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_stream[i]) send_byte(opening_stream[i]);
      drain_runs();

      // random part with idling on both sides
      random_burst(450);
      drain_runs();

      // long stretch with no idling at all
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      random_burst(800);

      // idling back on for the rest
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      random_burst(1150);

      drain_runs();
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/erle_pkg.sv
hw/rtl/erle_core.sv
hw/rtl/erle_queue.sv
hw/rtl/escape_rle_byte_decoder_unit.sv
hw/rtl/erle_checker.sv
test/erle_checker.sv
test/escape_rle_byte_decoder_unit_tb.sv
